/* rtl/dxt1_dxt5_block_decoder_defines.svh */
// assertion macros for the block decoder
`ifndef DXT1_DXT5_BLOCK_DECODER_DEFINES_SVH
`define DXT1_DXT5_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define DXT_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define DXT_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dxt_pkg.sv */
// shared types and constants of the block decoder
package dxt_pkg;

   localparam int unsigned MAX_SIDE_DEFAULT = 8192;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam int BLK_W   = 11;
   localparam int PIX_W   = 13;
   localparam int SIDE_W  = 14;
   localparam int CSR_IDX_W = 4;
   localparam int TEXELS  = 16;
   localparam int CNT_W   = $clog2(TEXELS);

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8192);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DXT5_MODE    = 4'd0,
      CSR_IMAGE_WIDTH  = 4'd1,
      CSR_IMAGE_HEIGHT = 4'd2
   } dxt_csr_type;

   typedef struct packed {
      logic              five;
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
   } dxt_cfg_type;

   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } dxt_bgr_type;

   typedef struct packed {
      dxt_bgr_type             e0;
      dxt_bgr_type             e1;
      logic [7:0]              a0;
      logic [7:0]              a1;
      logic                    four;
      logic                    five;
      logic [TEXELS-1:0][1:0]  cidx;
      logic [TEXELS-1:0][2:0]  aidx;
      logic [BLK_W-1:0]        bcol;
      logic [BLK_W-1:0]        brow;
   } dxt_stage_type;

   typedef struct packed {
      dxt_bgr_type [3:0]       pal;
      logic                    opaque3;
      logic                    five;
      logic [7:0][7:0]         atab;
      logic [TEXELS-1:0][1:0]  cidx;
      logic [TEXELS-1:0][2:0]  aidx;
      logic [BLK_W-1:0]        bcol;
      logic [BLK_W-1:0]        brow;
   } dxt_entry_type;

endpackage

/* rtl/dxt_req_if.sv */
// input channel: one compressed block per beat
interface dxt_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] colour_block;
   logic [63:0] alpha_block;
   logic [10:0] block_col;
   logic [10:0] block_row;

   modport source (output valid, colour_block, alpha_block, block_col, block_row,
                   input ready);
   modport sink   (input valid, colour_block, alpha_block, block_col, block_row,
                   output ready);
endinterface

/* rtl/dxt_rsp_if.sv */
// result channel: one texel per beat
interface dxt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  blue;
   logic [7:0]  green;
   logic [7:0]  red;
   logic [7:0]  alpha;
   logic [12:0] pixel_x;
   logic [12:0] pixel_y;
   logic        in_image;
   logic        last_texel;

   modport source (output valid, blue, green, red, alpha, pixel_x, pixel_y, in_image,
                   last_texel, input ready);
   modport sink   (input valid, blue, green, red, alpha, pixel_x, pixel_y, in_image,
                   last_texel, output ready);
endinterface

/* rtl/dxt_csr_if.sv */
// register write channel
interface dxt_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [13:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/dxt_front.sv */
// front end: takes blocks, expands endpoints, builds colour palette and alpha table
module dxt_front (
   input  logic                  clock,
   input  logic                  reset,
   dxt_req_if.sink               req_if,
   input  dxt_pkg::dxt_cfg_type  cfg,
   output logic                  push_valid,
   input  logic                  push_ready,
   output dxt_pkg::dxt_entry_type push_entry
);
   import dxt_pkg::*;

   localparam logic [13:0] Div31Mul = 14'd8457;
   localparam logic [14:0] Div63Mul = 15'd16645;
   localparam logic [9:0]  Div3Mul  = 10'd683;
   localparam logic [11:0] Div5Mul  = 12'd3277;
   localparam logic [11:0] Div7Mul  = 12'd2341;

   function automatic logic [7:0] exp5(input logic [4:0] v);
      logic [12:0] p;
      logic [26:0] q;
      p = 13'(v) * 13'd255;
      q = 27'(p) * 27'(Div31Mul);
      return q[25:18];
   endfunction

   function automatic logic [7:0] exp6(input logic [5:0] v);
      logic [13:0] p;
      logic [28:0] q;
      p = 14'(v) * 14'd255;
      q = 29'(p) * 29'(Div63Mul);
      return q[27:20];
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] q;
      q = 21'(x) * 21'(Div3Mul);
      return q[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [24:0] q;
      q = 25'(x) * 25'(Div5Mul);
      return q[21:14];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [24:0] q;
      q = 25'(x) * 25'(Div7Mul);
      return q[21:14];
   endfunction

   function automatic dxt_bgr_type expand(input logic [15:0] c);
      dxt_bgr_type e;
      e.r = exp5(c[15:11]);
      e.g = exp6(c[10:5]);
      e.b = exp5(c[4:0]);
      return e;
   endfunction

   function automatic logic [7:0] third(input logic [7:0] near, input logic [7:0] far);
      return div3({1'b0, near, 1'b0} + {2'b00, far});
   endfunction

   function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   logic          stage_valid_ff, stage_valid_in;
   dxt_stage_type stage_ff, stage_in;
   logic          accept;
   logic [6:1][10:0] sum7;
   logic [4:1][10:0] sum5;
   logic [6:1][7:0]  q7;
   logic [4:1][7:0]  q5;

   assign req_if.ready = !stage_valid_ff || push_ready;
   assign accept       = req_if.valid && req_if.ready;
   assign push_valid   = stage_valid_ff;

   always_comb begin
      stage_in.e0   = expand(req_if.colour_block[15:0]);
      stage_in.e1   = expand(req_if.colour_block[31:16]);
      stage_in.a0   = req_if.alpha_block[7:0];
      stage_in.a1   = req_if.alpha_block[15:8];
      stage_in.five = cfg.five;
      stage_in.four = cfg.five || (req_if.colour_block[15:0] > req_if.colour_block[31:16]);
      stage_in.cidx = req_if.colour_block[63:32];
      stage_in.aidx = req_if.alpha_block[63:16];
      stage_in.bcol = req_if.block_col;
      stage_in.brow = req_if.block_row;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   // alpha ramps
   for (genvar i = 1; i < 7; i++) begin : g_ramp7
      assign sum7[i] = 11'(7 - i) * 11'(stage_ff.a0) + 11'(i) * 11'(stage_ff.a1);
      assign q7[i]   = div7(sum7[i]);
   end

   for (genvar i = 1; i < 5; i++) begin : g_ramp5
      assign sum5[i] = 11'(5 - i) * 11'(stage_ff.a0) + 11'(i) * 11'(stage_ff.a1);
      assign q5[i]   = div5(sum5[i]);
   end

   always_comb begin
      push_entry.pal[0] = stage_ff.e0;
      push_entry.pal[1] = stage_ff.e1;
      if (stage_ff.four) begin
         push_entry.pal[2].b = third(stage_ff.e0.b, stage_ff.e1.b);
         push_entry.pal[2].g = third(stage_ff.e0.g, stage_ff.e1.g);
         push_entry.pal[2].r = third(stage_ff.e0.r, stage_ff.e1.r);
         push_entry.pal[3].b = third(stage_ff.e1.b, stage_ff.e0.b);
         push_entry.pal[3].g = third(stage_ff.e1.g, stage_ff.e0.g);
         push_entry.pal[3].r = third(stage_ff.e1.r, stage_ff.e0.r);
      end else begin
         push_entry.pal[2].b = half(stage_ff.e0.b, stage_ff.e1.b);
         push_entry.pal[2].g = half(stage_ff.e0.g, stage_ff.e1.g);
         push_entry.pal[2].r = half(stage_ff.e0.r, stage_ff.e1.r);
         push_entry.pal[3]   = '0;
      end
      push_entry.opaque3 = stage_ff.four;
      push_entry.five    = stage_ff.five;
      push_entry.atab[0] = stage_ff.a0;
      push_entry.atab[1] = stage_ff.a1;
      if (stage_ff.a0 > stage_ff.a1) begin
         for (int k = 1; k < 7; k++) begin
            push_entry.atab[k+1] = q7[k];
         end
      end else begin
         for (int k = 1; k < 5; k++) begin
            push_entry.atab[k+1] = q5[k];
         end
         push_entry.atab[6] = 8'h00;
         push_entry.atab[7] = 8'hFF;
      end
      push_entry.cidx = stage_ff.cidx;
      push_entry.aidx = stage_ff.aidx;
      push_entry.bcol = stage_ff.bcol;
      push_entry.brow = stage_ff.brow;
   end

endmodule

/* rtl/dxt_queue.sv */
// short queue of decoded blocks between front and back
module dxt_queue #(
   parameter int unsigned DEPTH = dxt_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  dxt_pkg::dxt_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output dxt_pkg::dxt_entry_type pop_entry
);
   import dxt_pkg::*;

   localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0]   LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CountW-1:0] Full    = CountW'(DEPTH);

   dxt_entry_type [DEPTH-1:0] slot_ff;
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != Full;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/dxt_back.sv */
// back end: walks the sixteen texels of a block into the output register
module dxt_back #(
   parameter int unsigned MAX_SIDE = dxt_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dxt_pkg::dxt_cfg_type   cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  dxt_pkg::dxt_entry_type pop_entry,
   dxt_rsp_if.source              rsp_if
);
   import dxt_pkg::*;
   `include "dxt1_dxt5_block_decoder_defines.svh"

   localparam int LimW = $clog2(MAX_SIDE + 1);
   localparam int CmpW = (LimW > SIDE_W) ? LimW : SIDE_W;
   localparam logic [CmpW-1:0] MaxLim = CmpW'(MAX_SIDE);
   localparam logic [CNT_W-1:0] LastCnt = CNT_W'(TEXELS - 1);

   dxt_entry_type    cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       blue_ff, green_ff, red_ff, alpha_ff;
   logic [7:0]       alpha_in;
   logic [PIX_W-1:0] x_ff, y_ff, x_in, y_in;
   logic             inside_ff, inside_in;
   logic             last_ff;
   logic             out_free, emit, last_tx, pop;
   logic [1:0]       sel;
   logic [2:0]       asel;
   dxt_bgr_type      texel;
   logic [CmpW-1:0]  w_lim, h_lim;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign emit      = cur_valid_ff && out_free;
   assign last_tx   = cnt_ff == LastCnt;
   assign pop_ready = !cur_valid_ff || (emit && last_tx);
   assign pop       = pop_valid && pop_ready;

   assign sel   = cur_ff.cidx[cnt_ff];
   assign asel  = cur_ff.aidx[cnt_ff];
   assign texel = cur_ff.pal[sel];
   assign x_in  = {cur_ff.bcol, cnt_ff[1:0]};
   assign y_in  = {cur_ff.brow, cnt_ff[3:2]};

   always_comb begin
      if (cur_ff.five) begin
         alpha_in = cur_ff.atab[asel];
      end else if (sel == 2'd3 && !cur_ff.opaque3) begin
         alpha_in = 8'h00;
      end else begin
         alpha_in = 8'hFF;
      end
   end

   // saturate sides to the largest supported image
   assign w_lim = (CmpW'(cfg.width) > MaxLim) ? MaxLim : CmpW'(cfg.width);
   assign h_lim = (CmpW'(cfg.height) > MaxLim) ? MaxLim : CmpW'(cfg.height);
   assign inside_in = (CmpW'(x_in) < w_lim) && (CmpW'(y_in) < h_lim);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      cnt_in       = cnt_ff;
      if (emit) begin
         cnt_in = cnt_ff + 1'b1;
         if (last_tx) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in       = pop_entry;
         cur_valid_in = 1'b1;
         cnt_in       = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         blue_ff   <= texel.b;
         green_ff  <= texel.g;
         red_ff    <= texel.r;
         alpha_ff  <= alpha_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         inside_ff <= inside_in;
         last_ff   <= last_tx;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.blue       = blue_ff;
   assign rsp_if.green      = green_ff;
   assign rsp_if.red        = red_ff;
   assign rsp_if.alpha      = alpha_ff;
   assign rsp_if.pixel_x    = x_ff;
   assign rsp_if.pixel_y    = y_ff;
   assign rsp_if.in_image   = inside_ff;
   assign rsp_if.last_texel = last_ff;

   `DXT_CHECK_NOW(a_idle_count_zero, !cur_valid_ff, cnt_ff == '0,
      "texel count not zero with no block in work")
   `DXT_CHECK_NEXT(a_count_steps, emit && !last_tx,
      cur_valid_ff && (cnt_ff == $past(cnt_ff) + 1'b1), "texel count skipped mid block")
   `DXT_CHECK_NOW(a_last_corner, rsp_valid_ff && last_ff,
      x_ff[1:0] == 2'b11 && y_ff[1:0] == 2'b11, "last texel not at block corner")

endmodule

/* rtl/dxt1_dxt5_block_decoder.sv */
// top level of the DXT1 / DXT5 block decoder
//
//  channel   modport  beat
//  req_if    sink     one compressed 4x4 block with block column and row
//  rsp_if    source   one BGRA texel with pixel coordinates, in-image and last flags
//  csr_if    sink     one register write: index, data (always ready)
//
//  one texel leaves per cycle while rsp_if does not stall; blocks follow back to back
//  a block passes the endpoint stage, the queue and the texel walk on its way to rsp_if
//  the texel walk in dxt_back sets the rate; the queue holds two decoded blocks
//  reset is synchronous: clears all valid state, mode to DXT1, sides to 8192
//  a stall on rsp_if holds the texel walk; the front takes blocks till queue and stage fill
module dxt1_dxt5_block_decoder #(
   parameter int unsigned MAX_SIDE = dxt_pkg::MAX_SIDE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   dxt_req_if.sink   req_if,
   dxt_rsp_if.source rsp_if,
   dxt_csr_if.sink   csr_if
);
   import dxt_pkg::*;

   logic              mode_ff, mode_in;
   logic [SIDE_W-1:0] width_ff, width_in;
   logic [SIDE_W-1:0] height_ff, height_in;
   logic              csr_write;
   dxt_cfg_type       cfg;

   logic              push_valid, push_ready, pop_valid, pop_ready;
   dxt_entry_type     push_entry, pop_entry;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_if.index)
            CSR_DXT5_MODE:    mode_in   = csr_if.data[0];
            CSR_IMAGE_WIDTH:  width_in  = csr_if.data;
            CSR_IMAGE_HEIGHT: height_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= SIDE_RESET;
         height_ff <= SIDE_RESET;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.five   = mode_ff;
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

   dxt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   dxt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   dxt_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_if    (rsp_if)
   );

endmodule
